// ===== sv/sscr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscr_pkg
// Shared types and constants of the serial speed command receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sscr_pkg;

    localparam logic [7:0] ACK_HEADER = 8'h55;
    localparam logic [7:0] CMD_ACCEL  = 8'h01;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_ACCEL   = 2'd1;
    localparam logic [1:0] MODE_DECEL   = 2'd2;
    localparam logic [1:0] MODE_LIMITED = 2'd3;

    localparam logic OP_BIT  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] REG_ENABLE      = 2'd0;
    localparam logic [1:0] REG_SPEED_LIMIT = 2'd1;
    localparam logic [1:0] REG_DECAY_STEP  = 2'd2;
    localparam logic [1:0] REG_TIMEOUT     = 2'd3;

    localparam logic [7:0] RST_SPEED_LIMIT = 8'd100;
    localparam logic [7:0] RST_DECAY_STEP  = 8'd10;
    localparam logic [7:0] RST_TIMEOUT     = 8'd2;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic       is_tick;
        logic       accel;
        logic [7:0] amount;
    } t_cmd;

    typedef struct packed {
        logic [7:0] speed_limit;
        logic [7:0] decay_step;
        logic [7:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic push;
        logic full;
    } t_qctl;

endpackage

`default_nettype wire

// ===== sv/serial_speed_command_receiver_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_speed_command_receiver_unit
// Receives checked 4-byte speed command frames bit by bit, applies speed
// commands and idle decay, and returns acknowledge frames.
//
// Channel   Direction  Handshake              Content
// s         in         i_s_tvalid/o_s_tready  bit or decay tick
// m         out        o_m_tvalid/i_m_tready  acknowledge frame
// cfg       in         i_cfg_valid/o_cfg_ready register write
//
// One request is taken per cycle while o_s_tready is high; a result passes
// through the command queue and then the output register. Synchronous reset
// clears all state and loads the register defaults. A stalled output fills
// the two-entry command queue, after which o_s_tready drops; bits that
// complete no good frame do not use the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_speed_command_receiver_unit #(
    parameter int QueueDepth = sscr_pkg::QUEUE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // [0] data_bit
    input  wire         i_s_tuser,   // [0] operation
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [31:0] o_m_tdata,   // [7:0] ack_header, [15:8] ack_speed,
                                     // [17:16] ack_state, [25:18] ack_checksum
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [7:0]  i_cfg_data
);

    logic             r_enable;
    sscr_pkg::t_cfg   r_cfg;
    sscr_pkg::t_qctl  w_qctl;
    sscr_pkg::t_cmd   w_front_cmd;
    sscr_pkg::t_cmd   w_back_cmd;
    logic             w_empty;
    logic             w_full;
    logic             w_pop;
    logic [7:0]       w_speed;
    logic [1:0]       w_state;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable            <= 1'b0;
            r_cfg.speed_limit   <= sscr_pkg::RST_SPEED_LIMIT;
            r_cfg.decay_step    <= sscr_pkg::RST_DECAY_STEP;
            r_cfg.timeout_ticks <= sscr_pkg::RST_TIMEOUT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sscr_pkg::REG_ENABLE:      r_enable            <= i_cfg_data[0];
                sscr_pkg::REG_SPEED_LIMIT: r_cfg.speed_limit   <= i_cfg_data;
                sscr_pkg::REG_DECAY_STEP:  r_cfg.decay_step    <= i_cfg_data;
                sscr_pkg::REG_TIMEOUT:     r_cfg.timeout_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sscr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_enable (r_enable),
        .i_accept (i_s_tvalid && o_s_tready),
        .i_op     (i_s_tuser),
        .i_bit    (i_s_tdata[0]),
        .i_full   (w_full),
        .o_qctl   (w_qctl),
        .o_cmd    (w_front_cmd)
    );

    sscr_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qctl  (w_qctl),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_back_cmd),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    sscr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (w_back_cmd),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_speed (w_speed),
        .o_state (w_state)
    );

    assign o_m_tdata = {6'd0,
                        sscr_pkg::ACK_HEADER ^ w_speed ^ {6'd0, w_state},
                        w_state,
                        w_speed,
                        sscr_pkg::ACK_HEADER};

`ifndef ASSERT_OFF
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_idle_means_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[17:16] == sscr_pkg::MODE_IDLE |-> o_m_tdata[15:8] == 8'd0)
        else $error("idle acknowledge with nonzero speed");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qctl.push |-> !w_full)
        else $error("command queue overrun");
`endif

endmodule

`default_nettype wire

// ===== sv/sscr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscr_front
// Collects serial bits into frames, checks them and queues good frames and
// decay ticks as commands.
// ----------------------------------------------------------------------------
`default_nettype none

module sscr_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_enable,
    input  wire               i_accept,
    input  wire               i_op,
    input  wire               i_bit,
    input  wire               i_full,
    output sscr_pkg::t_qctl   o_qctl,
    output sscr_pkg::t_cmd    o_cmd
);

    logic [31:0] r_shift;
    logic [31:0] n_shift;
    logic [4:0]  r_count;
    logic [4:0]  n_count;
    logic        w_good;
    logic        w_take;

    assign w_take  = i_accept && i_enable;
    assign n_shift = {r_shift[30:0], i_bit};
    assign w_good  = (n_shift[31:24] ^ n_shift[23:16] ^ n_shift[15:8]) == n_shift[7:0];

    always_comb begin
        n_count = r_count;
        o_qctl.push = 1'b0;
        o_qctl.full = i_full;
        o_cmd.is_tick = (i_op == sscr_pkg::OP_TICK);
        o_cmd.accel   = (n_shift[23:16] == sscr_pkg::CMD_ACCEL);
        o_cmd.amount  = n_shift[15:8];
        if (w_take) begin
            if (i_op == sscr_pkg::OP_TICK) begin
                o_qctl.push = 1'b1;
            end else begin
                n_count = r_count + 5'd1;
                if (r_count == 5'd31) begin
                    o_qctl.push = w_good;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_count <= '0;
        end else if (w_take && i_op == sscr_pkg::OP_BIT) begin
            r_shift <= n_shift;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sscr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscr_queue
// Small command queue between the frame front end and the speed back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sscr_queue #(
    parameter int Depth = sscr_pkg::QUEUE_DEPTH
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  sscr_pkg::t_qctl   i_qctl,
    input  sscr_pkg::t_cmd    i_cmd,
    input  wire               i_pop,
    output sscr_pkg::t_cmd    o_cmd,
    output logic              o_empty,
    output logic              o_full
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);

    sscr_pkg::t_cmd r_mem [Depth];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(Depth));
    assign w_push  = i_qctl.push && !i_qctl.full;
    assign w_pop   = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(Depth - 1)) ? '0 : r_wr + AW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(Depth - 1)) ? '0 : r_rd + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/sscr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscr_back
// Carries out queued commands on speed, mode and idle count, and holds the
// acknowledge in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sscr_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  sscr_pkg::t_cfg   i_cfg,
    input  sscr_pkg::t_cmd   i_cmd,
    input  wire              i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  wire              i_ready,
    output logic [7:0]       o_speed,
    output logic [1:0]       o_state
);

    logic [7:0] r_speed;
    logic [7:0] n_speed;
    logic [1:0] r_mode;
    logic [1:0] n_mode;
    logic [7:0] r_idle;
    logic [7:0] n_idle;
    logic       n_emit;
    logic [8:0] w_sum;
    logic [7:0] w_raised;
    logic       r_valid;
    logic [7:0] r_ack_speed;
    logic [1:0] r_ack_state;

    assign o_pop    = !i_empty && (!r_valid || i_ready);
    assign w_sum    = {1'b0, r_speed} + {1'b0, i_cmd.amount};
    assign w_raised = (r_speed >= i_cfg.speed_limit) ? r_speed :
                      (w_sum > {1'b0, i_cfg.speed_limit}) ? i_cfg.speed_limit : w_sum[7:0];

    always_comb begin
        n_speed = r_speed;
        n_mode  = r_mode;
        n_idle  = r_idle;
        n_emit  = 1'b0;
        if (i_cmd.is_tick) begin
            if (r_idle != 8'hFF) begin
                n_idle = r_idle + 8'd1;
            end
            if (n_idle > i_cfg.timeout_ticks && r_speed != 8'd0) begin
                if (r_speed <= i_cfg.decay_step) begin
                    n_speed = 8'd0;
                    n_mode  = sscr_pkg::MODE_IDLE;
                    n_emit  = 1'b1;
                end else begin
                    n_speed = r_speed - i_cfg.decay_step;
                    if (r_mode != sscr_pkg::MODE_IDLE) begin
                        n_mode = sscr_pkg::MODE_DECEL;
                        n_emit = 1'b1;
                    end
                end
            end
        end else begin
            n_idle = 8'd0;
            n_emit = 1'b1;
            if (i_cmd.accel) begin
                n_speed = w_raised;
                n_mode  = (w_raised == i_cfg.speed_limit) ? sscr_pkg::MODE_LIMITED
                                                          : sscr_pkg::MODE_ACCEL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= '0;
            r_mode  <= sscr_pkg::MODE_IDLE;
            r_idle  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_speed <= n_speed;
                r_mode  <= n_mode;
                r_idle  <= n_idle;
                r_valid <= n_emit;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && n_emit) begin
            r_ack_speed <= n_speed;
            r_ack_state <= n_mode;
        end
    end

    assign o_valid = r_valid;
    assign o_speed = r_ack_speed;
    assign o_state = r_ack_state;

endmodule

`default_nettype wire

// ===== bench/ack_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ack_frame_checker
// Watches the request, acknowledge and register write channels of the serial
// speed command receiver. It keeps its own copy of the receiver state, works
// out the acknowledge frame that each accepted request causes and compares
// every acknowledge frame that leaves the block with the oldest one waiting.
// ----------------------------------------------------------------------------
module ack_frame_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [7:0]  i_s_tdata,
    input  wire         i_s_tuser,
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [31:0] i_m_tdata,
    input  wire         i_cfg_valid,
    input  wire         i_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] header;
        logic [7:0] speed;
        logic [1:0] state;
        logic [7:0] checksum;
    } t_ack_frame;

    logic        cfg_enable;
    logic [7:0]  cfg_limit;
    logic [7:0]  cfg_step;
    logic [7:0]  cfg_timeout;

    logic [31:0] frame_bits;
    logic [4:0]  bits_seen;
    logic [7:0]  cur_speed;
    logic [1:0]  cur_mode;
    logic [7:0]  quiet_ticks;

    t_ack_frame  expected_acks[$];
    int          mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_ack_frame make_ack(input logic [7:0] spd, input logic [1:0] md);
        t_ack_frame a;
        a.header   = sscr_pkg::ACK_HEADER;
        a.speed    = spd;
        a.state    = md;
        a.checksum = sscr_pkg::ACK_HEADER ^ spd ^ {6'd0, md};
        return a;
    endfunction

    function automatic bit advance_receiver(input logic op, input logic data_bit,
                                            output t_ack_frame ack);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [8:0] sum;
        ack = '0;
        if (!cfg_enable) begin
            return 1'b0;
        end
        if (op == sscr_pkg::OP_BIT) begin
            frame_bits = {frame_bits[30:0], data_bit};
            if (bits_seen != 5'd31) begin
                bits_seen = bits_seen + 5'd1;
                return 1'b0;
            end
            bits_seen = 5'd0;
            b0 = frame_bits[31:24];
            b1 = frame_bits[23:16];
            b2 = frame_bits[15:8];
            b3 = frame_bits[7:0];
            if ((b0 ^ b1 ^ b2) != b3) begin
                return 1'b0;
            end
            quiet_ticks = 8'd0;
            if (b1 == sscr_pkg::CMD_ACCEL) begin
                if (cur_speed < cfg_limit) begin
                    sum = {1'b0, cur_speed} + {1'b0, b2};
                    cur_speed = (sum > {1'b0, cfg_limit}) ? cfg_limit : sum[7:0];
                end
                cur_mode = (cur_speed == cfg_limit) ? sscr_pkg::MODE_LIMITED
                                                    : sscr_pkg::MODE_ACCEL;
            end
            ack = make_ack(cur_speed, cur_mode);
            return 1'b1;
        end
        if (quiet_ticks != 8'd255) begin
            quiet_ticks = quiet_ticks + 8'd1;
        end
        if (quiet_ticks <= cfg_timeout || cur_speed == 8'd0) begin
            return 1'b0;
        end
        if (cur_speed <= cfg_step) begin
            cur_speed = 8'd0;
            cur_mode  = sscr_pkg::MODE_IDLE;
            ack = make_ack(cur_speed, cur_mode);
            return 1'b1;
        end
        cur_speed = cur_speed - cfg_step;
        if (cur_mode != sscr_pkg::MODE_IDLE) begin
            cur_mode = sscr_pkg::MODE_DECEL;
            ack = make_ack(cur_speed, cur_mode);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_ack_frame got;
        t_ack_frame want;
        if (!i_rst_n) begin
            cfg_enable  = 1'b0;
            cfg_limit   = sscr_pkg::RST_SPEED_LIMIT;
            cfg_step    = sscr_pkg::RST_DECAY_STEP;
            cfg_timeout = sscr_pkg::RST_TIMEOUT;
            frame_bits  = '0;
            bits_seen   = '0;
            cur_speed   = '0;
            cur_mode    = sscr_pkg::MODE_IDLE;
            quiet_ticks = '0;
            expected_acks.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    sscr_pkg::REG_ENABLE:      cfg_enable  = i_cfg_data[0];
                    sscr_pkg::REG_SPEED_LIMIT: cfg_limit   = i_cfg_data;
                    sscr_pkg::REG_DECAY_STEP:  cfg_step    = i_cfg_data;
                    sscr_pkg::REG_TIMEOUT:     cfg_timeout = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.header   = i_m_tdata[7:0];
                got.speed    = i_m_tdata[15:8];
                got.state    = i_m_tdata[17:16];
                got.checksum = i_m_tdata[25:18];
                if (expected_acks.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected ack: header %h speed %h state %0d checksum %h",
                                 $realtime, got.header, got.speed, got.state, got.checksum);
                    end
                end else begin
                    want = expected_acks.pop_front();
                    if (got.header != want.header || got.speed != want.speed ||
                        got.state != want.state || got.checksum != want.checksum) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: ack mismatch: expected %h/%h/%0d/%h, got %h/%h/%0d/%h",
                                     $realtime, want.header, want.speed, want.state,
                                     want.checksum, got.header, got.speed, got.state,
                                     got.checksum);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (advance_receiver(i_s_tuser, i_s_tdata[0], want)) begin
                    expected_acks.push_back(want);
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_acks.size();
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the serial speed command receiver with directed and random command
// frames, bad frames, stray bits and decay ticks across several register
// settings, stalls both channels at random, and reports the verdict from the
// acknowledge frame checker.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ITEM_TARGET  = 1100;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 600;
    localparam int PHASE_ITEMS  = 150;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic [7:0]  i_s_tdata   = '0;
    logic        i_s_tuser   = 1'b0;
    logic        i_m_tready  = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data  = '0;
    wire         o_s_tready;
    wire         o_m_tvalid;
    wire  [31:0] o_m_tdata;
    wire         o_cfg_ready;

    int fail_count;
    int pending;
    int items_sent = 0;
    int frame_pos  = 0;
    bit calm       = 1'b0;
    bit enabled    = 1'b0;

    serial_speed_command_receiver_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    ack_frame_checker ack_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin : timeout_guard
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("*** FAILED ***");
        $finish;
    end

    // The acknowledge side holds off once for a long stretch so that the
    // command queue fills and the request side is stalled.
    initial begin : ack_sink
        int hold = 0;
        bit held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                i_m_tready <= 1'b0;
            end else if (!held && items_sent >= HOLD_AT) begin
                held = 1'b1;
                hold = HOLD_CYCLES;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= calm || ($urandom_range(99) >= 33);
            end
        end
    end

    task automatic send_item(input logic op, input logic data_bit);
        while (!calm && $urandom_range(99) < 33) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {7'd0, data_bit};
        do @(posedge i_clk); while (!o_s_tready);
        if (enabled) begin
            items_sent++;
            if (op == sscr_pkg::OP_BIT) begin
                frame_pos = (frame_pos + 1) % 32;
            end
        end
        calm = (items_sent >= 500 && items_sent < 700);
    endtask

    task automatic send_bits(input logic [31:0] word, input int hi, input int lo);
        for (int i = hi; i >= lo; i--) begin
            send_item(sscr_pkg::OP_BIT, word[i]);
        end
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(sscr_pkg::OP_TICK, 1'($urandom_range(1)));
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_item(1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    function automatic logic [31:0] make_frame(input logic [7:0] b0, input logic [7:0] b1,
                                               input logic [7:0] b2, input bit bad);
        logic [7:0] b3;
        b3 = b0 ^ b1 ^ b2;
        if (bad) begin
            b3 = b3 ^ (8'd1 << $urandom_range(7));
        end
        return {b0, b1, b2, b3};
    endfunction

    task automatic send_frame(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input bit bad);
        logic [31:0] word;
        int          split;
        while (frame_pos != 0) begin
            send_item(sscr_pkg::OP_BIT, 1'($urandom_range(1)));
        end
        word = make_frame(b0, b1, b2, bad);
        if ($urandom_range(7) == 0) begin
            split = int'($urandom_range(1, 30));
            send_bits(word, 31, split);
            send_ticks(int'($urandom_range(1, 3)));
            send_bits(word, split - 1, 0);
        end else begin
            send_bits(word, 31, 0);
        end
    endtask

    task automatic wait_idle;
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == sscr_pkg::REG_ENABLE) begin
            enabled = value[0];
        end
    endtask

    task automatic set_config(input bit en, input logic [7:0] limit,
                              input logic [7:0] step, input logic [7:0] timeout);
        wait_idle();
        write_register(sscr_pkg::REG_SPEED_LIMIT, limit);
        write_register(sscr_pkg::REG_DECAY_STEP, step);
        write_register(sscr_pkg::REG_TIMEOUT, timeout);
        write_register(sscr_pkg::REG_ENABLE, {7'd0, en});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_enable(input bit en);
        wait_idle();
        write_register(sscr_pkg::REG_ENABLE, {7'd0, en});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic new_phase(input int phase_no);
        logic [7:0] limit;
        logic [7:0] step;
        logic [7:0] timeout;
        case ($urandom_range(4))
            0:       limit = 8'd1;
            1:       limit = 8'd255;
            2:       limit = 8'd0;
            default: limit = 8'($urandom_range(1, 255));
        endcase
        case ($urandom_range(4))
            0:       step = 8'd1;
            1:       step = 8'd255;
            2:       step = 8'd0;
            default: step = 8'($urandom_range(1, 40));
        endcase
        if (phase_no == 2) begin
            timeout = 8'd254;
        end else if (phase_no == 4) begin
            timeout = 8'd255;
        end else begin
            timeout = 8'($urandom_range(0, 6));
        end
        set_config(1'b1, limit, step, timeout);
        if (timeout >= 8'd254) begin
            send_frame(8'($urandom_range(255)), sscr_pkg::CMD_ACCEL, 8'd200, 1'b0);
            send_ticks(260);
        end
    endtask

    initial begin : stimulus
        logic [31:0] word;
        int          pick;
        int          phase_mark;
        int          phase_no;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Requests while disabled are ignored.
        send_item(sscr_pkg::OP_BIT, 1'b1);
        send_item(sscr_pkg::OP_TICK, 1'b0);
        send_item(sscr_pkg::OP_BIT, 1'b0);

        set_config(1'b1, sscr_pkg::RST_SPEED_LIMIT, sscr_pkg::RST_DECAY_STEP,
                   sscr_pkg::RST_TIMEOUT);
        send_frame(8'hA5, sscr_pkg::CMD_ACCEL, 8'd50, 1'b0);
        send_frame(8'h00, sscr_pkg::CMD_ACCEL, 8'hFF, 1'b0);
        send_frame(8'hFF, 8'h7E, 8'h12, 1'b0);
        send_frame(8'h3C, sscr_pkg::CMD_ACCEL, 8'h05, 1'b1);
        send_ticks(4);

        set_config(1'b1, 8'd0, 8'd0, 8'd0);
        send_frame(8'h01, sscr_pkg::CMD_ACCEL, 8'h0A, 1'b0);
        send_ticks(1);

        set_config(1'b1, 8'd255, 8'd255, 8'd0);
        send_frame(8'h80, sscr_pkg::CMD_ACCEL, 8'hFF, 1'b0);
        send_ticks(2);
        send_frame(8'h7F, sscr_pkg::CMD_ACCEL, 8'h00, 1'b0);

        set_config(1'b1, 8'd0, 8'd1, 8'd0);
        send_frame(8'h11, sscr_pkg::CMD_ACCEL, 8'h20, 1'b0);

        // A partial frame is kept across a disable.
        word = make_frame(8'h5A, sscr_pkg::CMD_ACCEL, 8'h07, 1'b0);
        send_bits(word, 31, 16);
        set_enable(1'b0);
        send_noise(6);
        set_enable(1'b1);
        send_bits(word, 15, 0);

        phase_mark = items_sent;
        phase_no   = 0;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent - phase_mark >= PHASE_ITEMS) begin
                new_phase(phase_no);
                phase_no++;
                phase_mark = items_sent;
            end
            pick = int'($urandom_range(99));
            if (pick < 70) begin
                send_frame(8'($urandom_range(255)),
                           ($urandom_range(9) < 7) ? sscr_pkg::CMD_ACCEL
                                                   : 8'($urandom_range(255)),
                           $urandom_range(1) ? 8'($urandom_range(40)) : 8'($urandom_range(255)),
                           $urandom_range(9) == 0);
            end else if (pick < 86) begin
                send_ticks(int'($urandom_range(1, 8)));
            end else if (pick < 97) begin
                send_noise(int'($urandom_range(1, 20)));
            end else begin
                set_enable(1'b0);
                send_noise(int'($urandom_range(5, 20)));
                set_enable(1'b1);
            end
        end

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
